>>> rtl/hcb_pkg.sv
// ----------------------------------------------------------------------------
// hcb_pkg - shared types and constants
// Widths, key reset values, register indexes and the mod 26 reduction
// constants for the 4x4 Hill cipher block.
// ----------------------------------------------------------------------------
package hcb_pkg;

   localparam int BLOCK_SIZE = 4;                // letters per block, 2..4
   localparam int LETTER_W   = 5;
   localparam int ROW_W      = 20;               // four 5-bit entries
   localparam int MAT_ROWS   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int POS_W      = (BLOCK_SIZE > 2) ? $clog2(BLOCK_SIZE) : 1;

   localparam int MODULUS    = 26;
   localparam logic [LETTER_W-1:0] PAD_LETTER = LETTER_W'(25);  // 'Z'

   // worst case column sum: every letter and entry at 31
   localparam int ACC_MAX     = BLOCK_SIZE * 31 * 31;
   localparam int ACC_W       = $clog2(ACC_MAX + 1);
   // quotient by reciprocal, exact for every sum below 2**ACC_W
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (1 << RECIP_SHIFT) / MODULUS + 1;
   localparam int RECIP_W     = $clog2(RECIP + 1);
   localparam int PROD_W      = ACC_W + RECIP_W;
   localparam int Q_W         = $clog2(((1 << ACC_W) - 1) / MODULUS + 1);

   typedef logic [LETTER_W-1:0]              letter_type;
   typedef logic [POS_W-1:0]                 pos_type;
   typedef letter_type [BLOCK_SIZE-1:0]      vec_type;
   typedef logic [ROW_W-1:0]                 row_type;
   typedef row_type [MAT_ROWS-1:0]           matrix_type;
   typedef logic [ACC_W-1:0]                 acc_type;
   typedef logic [Q_W-1:0]                   quot_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_ROW_0 = 3'd0,
      CSR_KEY_ROW_1 = 3'd1,
      CSR_KEY_ROW_2 = 3'd2,
      CSR_KEY_ROW_3 = 3'd3,
      CSR_INV_ROW_0 = 3'd4,
      CSR_INV_ROW_1 = 3'd5,
      CSR_INV_ROW_2 = 3'd6,
      CSR_INV_ROW_3 = 3'd7
   } csr_idx_type;

   // 9,7,11,13 / 4,7,5,6 / 2,21,14,9 / 3,23,21,8
   localparam matrix_type KEY_RESET = '{
      20'd284387, 20'd309922, 20'd201956, 20'd437481
   };

   typedef struct packed {
      logic block_last;
      logic message_last;
   } tag_type;

   // one column of a block, handed from the gatherer to the MAC pipeline
   typedef struct packed {
      vec_type vec;
      pos_type col;
      logic    decrypt;
      tag_type tag;
   } col_item_type;

endpackage

>>> rtl/hcb_if.sv
// ----------------------------------------------------------------------------
// hcb_req_if / hcb_rsp_if - request and response channels
// Valid/ready channels carrying input letters and cipher output letters.
// ----------------------------------------------------------------------------
interface hcb_req_if;
   logic                          valid;
   logic                          ready;
   logic [hcb_pkg::LETTER_W-1:0]  letter;
   logic                          message_end;
   logic                          decrypt;

   modport source (output valid, output letter, output message_end,
                   output decrypt, input ready);
   modport sink   (input valid, input letter, input message_end,
                   input decrypt, output ready);
endinterface

interface hcb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hcb_pkg::LETTER_W-1:0]  out_letter;
   logic                          block_last;
   logic                          message_last;

   modport source (output valid, output out_letter, output block_last,
                   output message_last, input ready);
   modport sink   (input valid, input out_letter, input block_last,
                   input message_last, output ready);
endinterface

>>> rtl/hcb_gather.sv
// ----------------------------------------------------------------------------
// hcb_gather - letter gathering and column sequencing
// Collects letters into a block, pads on message end, then issues the
// block once per output column.
// ----------------------------------------------------------------------------
module hcb_gather (
   input  logic                  clock,
   input  logic                  reset,
   hcb_req_if.sink               req,
   output logic                  col_valid,
   input  logic                  col_ready,
   output hcb_pkg::col_item_type col_item
);
   import hcb_pkg::*;

   localparam pos_type LAST_POS = POS_W'(BLOCK_SIZE - 1);

   letter_type [BLOCK_SIZE-1:0] buf_ff;
   pos_type                     fill_ff;
   pos_type                     fill_in;
   logic                        blk_valid_ff, blk_valid_in;
   vec_type                     vec_ff, vec_in;
   pos_type                     col_ff, col_in;
   logic                        dec_ff, dec_in;
   logic                        end_ff, end_in;
   logic                        complete;
   logic                        blk_free;
   logic                        accept;
   logic                        col_done;

   always_comb begin
      complete = (fill_ff == LAST_POS) || req.message_end;
      col_done = blk_valid_ff && col_ready && (col_ff == LAST_POS);
      blk_free = !blk_valid_ff || col_done;
      // a letter that closes a block needs the block register
      req.ready = complete ? blk_free : 1'b1;
      accept    = req.valid && req.ready;

      for (int k = 0; k < BLOCK_SIZE; k++) begin
         if (POS_W'(k) < fill_ff)
            vec_in[k] = buf_ff[k];
         else if (POS_W'(k) == fill_ff)
            vec_in[k] = req.letter;
         else
            vec_in[k] = PAD_LETTER;
      end

      fill_in      = fill_ff;
      blk_valid_in = blk_valid_ff;
      col_in       = col_ff;
      dec_in       = dec_ff;
      end_in       = end_ff;

      if (blk_valid_ff && col_ready) begin
         if (col_ff == LAST_POS)
            blk_valid_in = 1'b0;
         else
            col_in = col_ff + POS_W'(1);
      end

      if (accept) begin
         if (complete) begin
            fill_in      = '0;
            blk_valid_in = 1'b1;
            col_in       = '0;
            dec_in       = req.decrypt;
            end_in       = req.message_end;
         end else begin
            fill_in = fill_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         blk_valid_ff <= 1'b0;
         col_ff       <= '0;
      end else begin
         fill_ff      <= fill_in;
         blk_valid_ff <= blk_valid_in;
         col_ff       <= col_in;
      end
      dec_ff <= dec_in;
      end_ff <= end_in;
      if (accept && !complete)
         buf_ff[fill_ff] <= req.letter;
      if (accept && complete)
         vec_ff <= vec_in;
   end

   always_comb begin
      col_valid                 = blk_valid_ff;
      col_item.vec              = vec_ff;
      col_item.col              = col_ff;
      col_item.decrypt          = dec_ff;
      col_item.tag.block_last   = (col_ff == LAST_POS);
      col_item.tag.message_last = end_ff && (col_ff == LAST_POS);
   end

endmodule

>>> rtl/hcb_mac.sv
// ----------------------------------------------------------------------------
// hcb_mac - column multiply-accumulate and mod 26 reduction
// Dot product of the block with one matrix column, quotient by reciprocal,
// then residue into the response register.
// ----------------------------------------------------------------------------
module hcb_mac (
   input  logic                  clock,
   input  logic                  reset,
   input  hcb_pkg::matrix_type   key_rows,
   input  hcb_pkg::matrix_type   inv_rows,
   input  logic                  col_valid,
   output logic                  col_ready,
   input  hcb_pkg::col_item_type col_item,
   hcb_rsp_if.source             rsp
);
   import hcb_pkg::*;

   logic                        a_valid_ff, b_valid_ff, c_valid_ff;
   logic                        adv_a, adv_b, adv_c;
   acc_type                     a_acc_ff, a_acc_in;
   tag_type                     a_tag_ff;
   acc_type                     b_acc_ff;
   quot_type                    b_q_ff, b_q_in;
   tag_type                     b_tag_ff;
   letter_type                  c_letter_ff, c_letter_in;
   tag_type                     c_tag_ff;
   matrix_type                  rows;
   logic [PROD_W-1:0]           recip_prod;
   acc_type                     residue;

   always_comb begin
      adv_c     = !c_valid_ff || rsp.ready;
      adv_b     = !b_valid_ff || adv_c;
      adv_a     = !a_valid_ff || adv_b;
      col_ready = adv_a;

      rows     = col_item.decrypt ? inv_rows : key_rows;
      a_acc_in = '0;
      for (int k = 0; k < BLOCK_SIZE; k++)
         a_acc_in = a_acc_in + ACC_W'(col_item.vec[k])
                    * ACC_W'(rows[k][col_item.col * LETTER_W +: LETTER_W]);

      recip_prod = PROD_W'(a_acc_ff) * PROD_W'(RECIP);
      b_q_in     = recip_prod[RECIP_SHIFT +: Q_W];

      residue     = b_acc_ff - ACC_W'(b_q_ff * MODULUS);
      c_letter_in = residue[LETTER_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (adv_a) a_valid_ff <= col_valid;
         if (adv_b) b_valid_ff <= a_valid_ff;
         if (adv_c) c_valid_ff <= b_valid_ff;
      end
      if (adv_a) begin
         a_acc_ff <= a_acc_in;
         a_tag_ff <= col_item.tag;
      end
      if (adv_b) begin
         b_acc_ff <= a_acc_ff;
         b_q_ff   <= b_q_in;
         b_tag_ff <= a_tag_ff;
      end
      if (adv_c) begin
         c_letter_ff <= c_letter_in;
         c_tag_ff    <= b_tag_ff;
      end
   end

   always_comb begin
      rsp.valid        = c_valid_ff;
      rsp.out_letter   = c_letter_ff;
      rsp.block_last   = c_tag_ff.block_last;
      rsp.message_last = c_tag_ff.message_last;
   end

endmodule

>>> rtl/hill_cipher_block_mod26_top.sv
// ----------------------------------------------------------------------------
// hill_cipher_block_mod26_top - 4x4 Hill cipher, modulo 26
// Gathers letters into blocks, pads with 'Z' on message end and multiplies each
// block by key or loaded inverse matrix, one letter per cycle while rsp ready.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake         payload
//  req      in         valid / ready     letter, message_end, decrypt
//  rsp      out        valid / ready     out_letter, block_last, message_last
//  csr      in         csr_we (no wait)  csr_index, csr_wdata
//
// One request per cycle is accepted, unless a closing request waits for the
// block register; a full block gives four responses, so with rsp ready full
// blocks stream at one letter per cycle. The column sequencer is the limit:
// a short block closed by message_end still gives four responses. A closing
// request travels through the block register and three pipeline stages
// before the first response of its block leaves. Reset is synchronous: it
// clears the fill count and the block and pipeline valids, loads the default
// key and zeroes the inverse rows.
// A stalled rsp backs up through the pipeline; only the request that closes a
// block waits for the block register, other requests are always taken.
//
module hill_cipher_block_mod26_top (
   input  logic                          clock,
   input  logic                          reset,
   hcb_req_if.sink                       req,
   hcb_rsp_if.source                     rsp,
   input  logic                          csr_we,
   input  logic [hcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hcb_pkg::ROW_W-1:0]     csr_wdata
);
   import hcb_pkg::*;

   matrix_type   key_ff;
   matrix_type   inv_ff;
   logic         col_valid;
   logic         col_ready;
   col_item_type col_item;

   // register file: rows packed as four 5-bit entries, entry j at bit 5j
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
         inv_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_KEY_ROW_0: key_ff[0] <= csr_wdata;
            CSR_KEY_ROW_1: key_ff[1] <= csr_wdata;
            CSR_KEY_ROW_2: key_ff[2] <= csr_wdata;
            CSR_KEY_ROW_3: key_ff[3] <= csr_wdata;
            CSR_INV_ROW_0: inv_ff[0] <= csr_wdata;
            CSR_INV_ROW_1: inv_ff[1] <= csr_wdata;
            CSR_INV_ROW_2: inv_ff[2] <= csr_wdata;
            CSR_INV_ROW_3: inv_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // block gathering and column issue
   hcb_gather u_gather (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .col_valid (col_valid),
      .col_ready (col_ready),
      .col_item  (col_item)
   );

   // dot product, reciprocal quotient, residue into response register
   hcb_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .key_rows  (key_ff),
      .inv_rows  (inv_ff),
      .col_valid (col_valid),
      .col_ready (col_ready),
      .col_item  (col_item),
      .rsp       (rsp)
   );

endmodule

>>> bench/tb_hill_cipher_block_mod26_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hill_cipher_block_mod26_top - self-checking bench for the Hill cipher
// Letter requests go in through a queue-fed valid/ready driver. An
// independent mod 26 block model predicts each output letter, and the
// monitor checks the responses in order. The run covers several key
// settings and several idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_hill_cipher_block_mod26_top;
   import hcb_pkg::*;

   localparam int CIPHER_MOD    = 26;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int HOLD_CYCLES   = 200;      // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;        // pipeline depth is four, doubled
   localparam int PRINT_CAP     = 40;
   localparam letter_type Z_LETTER = 5'd25;

   typedef struct packed {
      letter_type letter;
      logic       message_end;
      logic       decrypt;
   } plain_req_type;

   typedef struct packed {
      letter_type out_letter;
      logic       block_last;
      logic       message_last;
   } cipher_rsp_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [ROW_W-1:0]     csr_wdata;

   hcb_req_if req_if ();
   hcb_rsp_if rsp_if ();

   hill_cipher_block_mod26_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --- bench state ---------------------------------------------------------
   plain_req_type  pending_reqs [$];      // requests still to be offered
   cipher_rsp_type expected_rsps [$];     // predicted letters, oldest first
   int          mismatches = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;     // chance per free cycle of offering nothing
   int          recv_stall_pct = 0;    // chance per cycle of dropping rsp ready
   int          hold_kick = 0;         // bumped to start a long hold-off
   int          hold_seen = 0;
   int          hold_left = 0;

   // predictor's own copy of the registers and the gathering buffer
   matrix_type  key_copy;
   matrix_type  inv_copy;
   letter_type  block_buf [BLOCK_SIZE];
   int          fill_cnt;

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // One accepted request: buffer it and, if it closes a block, pad with 'Z'
   // and multiply the row vector by the selected matrix, mod 26.
   function automatic void hill_step(plain_req_type rq);
      letter_type     vec [BLOCK_SIZE];
      matrix_type     m;
      int unsigned    acc;
      cipher_rsp_type r;
      block_buf[fill_cnt] = rq.letter;
      fill_cnt++;
      if (fill_cnt < BLOCK_SIZE && !rq.message_end)
         return;
      // the closing request's flag picks the matrix for the whole block
      m = rq.decrypt ? inv_copy : key_copy;
      for (int k = 0; k < BLOCK_SIZE; k++)
         vec[k] = (k < fill_cnt) ? block_buf[k] : Z_LETTER;
      for (int j = 0; j < BLOCK_SIZE; j++) begin
         acc = 0;
         // raw 5-bit letters and entries, 26..31 included
         for (int k = 0; k < BLOCK_SIZE; k++)
            acc += int'(vec[k]) * int'(m[k][LETTER_W*j +: LETTER_W]);
         r.out_letter   = letter_type'(acc % CIPHER_MOD);
         r.block_last   = (j == BLOCK_SIZE - 1);
         r.message_last = rq.message_end && (j == BLOCK_SIZE - 1);
         expected_rsps.push_back(r);
      end
      fill_cnt = 0;
   endfunction

   // --- driver: offers queued requests, predicts on each handshake ----------
   plain_req_type taken;
   plain_req_type offer;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         fill_cnt = 0;
         for (int k = 0; k < BLOCK_SIZE; k++)
            block_buf[k] = '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            taken.letter      = req_if.letter;
            taken.message_end = req_if.message_end;
            taken.decrypt     = req_if.decrypt;
            hill_step(taken);
         end
         // slot is free: either nothing on the bus or it has just gone
         if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offer = pending_reqs.pop_front();
               req_if.valid       <= 1'b1;
               req_if.letter      <= offer.letter;
               req_if.message_end <= offer.message_end;
               req_if.decrypt     <= offer.decrypt;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // --- monitor: checks each response against the oldest prediction --------
   cipher_rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response, letter %0d",
                                         rsp_if.out_letter));
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_if.out_letter !== want.out_letter)
                  report_mismatch($sformatf("out_letter %0d, want %0d",
                                            rsp_if.out_letter, want.out_letter));
               if (rsp_if.block_last !== want.block_last)
                  report_mismatch($sformatf("block_last %b, want %b",
                                            rsp_if.block_last, want.block_last));
               if (rsp_if.message_last !== want.message_last)
                  report_mismatch($sformatf("message_last %b, want %b",
                                            rsp_if.message_last, want.message_last));
            end
         end
         rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long hold-off on rsp, counted here so the driver keeps offering meanwhile
   always @(posedge clock) begin
      if (reset) begin
         hold_seen <= 0;
         hold_left <= 0;
      end else if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   // --- stimulus helpers ----------------------------------------------------
   task automatic push_req(int unsigned letter, bit msg_end, bit dec);
      plain_req_type rq;
      rq.letter      = letter_type'(letter);
      rq.message_end = msg_end;
      rq.decrypt     = dec;
      pending_reqs.push_back(rq);
   endtask

   // Well-formed messages of random length, each closed by message_end, so
   // the buffer is empty at every phase boundary. Some mix the decrypt flag.
   task automatic add_messages(int count);
      int  added;
      int  len;
      bit  dec_msg;
      bit  mixed;
      added = 0;
      while (added < count) begin
         len     = $urandom_range(12, 1);
         dec_msg = $urandom_range(1);
         mixed   = ($urandom_range(4) == 0);
         for (int i = 0; i < len; i++) begin
            push_req(($urandom_range(9) == 0) ? $urandom_range(31, 26)
                                              : $urandom_range(25),
                     (i == len - 1),
                     mixed ? $urandom_range(1) : dec_msg);
         end
         added += len;
      end
   endtask

   function automatic matrix_type random_matrix(int max_entry);
      matrix_type m;
      for (int r = 0; r < MAT_ROWS; r++)
         for (int c = 0; c < MAT_ROWS; c++)
            m[r][LETTER_W*c +: LETTER_W] = letter_type'($urandom_range(max_entry));
      return m;
   endfunction

   function automatic matrix_type flat_matrix(row_type v);
      matrix_type m;
      for (int r = 0; r < MAT_ROWS; r++)
         m[r] = v;
      return m;
   endfunction

   // everything offered, taken and answered; sampled away from the edge
   task automatic wait_drained();
      do
         @(negedge clock);
      while (!(pending_reqs.size() == 0 && !req_if.valid && expected_rsps.size() == 0));
   endtask

   // Register writes happen only here, with the block idle.
   task automatic next_phase(matrix_type k, matrix_type iv, int send_pct, int recv_pct);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      for (int r = 0; r < MAT_ROWS; r++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(CSR_KEY_ROW_0 + r);
         csr_wdata <= k[r];
         key_copy[r] = k[r];
      end
      for (int r = 0; r < MAT_ROWS; r++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= CSR_IDX_W'(CSR_INV_ROW_0 + r);
         csr_wdata <= iv[r];
         inv_copy[r] = iv[r];
      end
      @(posedge clock);
      csr_we         <= 1'b0;
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
      @(negedge clock);
   endtask

   // --- sequence ------------------------------------------------------------
   initial begin
      req_if.valid       = 1'b0;
      req_if.letter      = '0;
      req_if.message_end = 1'b0;
      req_if.decrypt     = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_we             = 1'b0;
      csr_index          = CSR_KEY_ROW_0;
      csr_wdata          = '0;
      // reset key 9,7,11,13 / 4,7,5,6 / 2,21,14,9 / 3,23,21,8, inverse zero
      key_copy[0] = 20'd437481;
      key_copy[1] = 20'd201956;
      key_copy[2] = 20'd309922;
      key_copy[3] = 20'd284387;
      inv_copy    = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed, with reset registers and no idling.
      // all letters at the bottom of the range
      for (int i = 0; i < 4; i++) push_req(0, 0, 0);
      // letters above 'Z' are used raw
      push_req(26, 0, 0);
      push_req(27, 0, 0);
      push_req(30, 0, 0);
      push_req(31, 0, 0);
      // all 'Z', message end on the fourth letter: full block, no padding
      for (int i = 0; i < 4; i++) push_req(25, (i == 3), 0);
      // message ends after one, two and three letters: padded with 'Z'
      push_req(1, 1, 0);
      push_req(2, 0, 0);
      push_req(3, 1, 0);
      push_req(4, 0, 0);
      push_req(5, 0, 0);
      push_req(6, 1, 0);
      // mixed flags, closing letter asks for decrypt with an unloaded inverse
      push_req(7, 0, 0);
      push_req(8, 0, 0);
      push_req(9, 0, 1);
      push_req(10, 1, 1);
      add_messages(20);

      // top of the entry range everywhere, sender mostly idle
      next_phase(flat_matrix('1), flat_matrix('1), 70, 0);
      add_messages(20);

      // legal random key and inverse, receiver mostly stalled
      next_phase(random_matrix(25), random_matrix(25), 0, 70);
      add_messages(20);

      // zero key, raw-range inverse, both sides idling
      next_phase(flat_matrix('0), random_matrix(31), 37, 37);
      add_messages(20);

      // raw-range entries; receiver held off while requests keep coming,
      // so the pipeline fills and the closing request stalls
      next_phase(random_matrix(31), random_matrix(31), 0, 0);
      @(posedge clock);
      hold_kick <= hold_kick + 1;
      @(negedge clock);
      add_messages(20);

      // back to legal entries, streaming flat out
      next_phase(random_matrix(25), random_matrix(25), 0, 0);
      add_messages(20);

      wait_drained();
      repeat (SETTLE_CYCLES * 4) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/hcb_pkg.sv
rtl/hcb_if.sv
rtl/hcb_gather.sv
rtl/hcb_mac.sv
rtl/hill_cipher_block_mod26_top.sv
bench/tb_hill_cipher_block_mod26_top.sv
